// File: rtl/tap_hold_dimmer_control_assert.svh
// ----------------------------------------------------------------------------
// Tap-and-hold dimmer assertion macros
// Shorthand for the concurrent checks in the dimmer RTL.
// ----------------------------------------------------------------------------
`ifndef TAP_HOLD_DIMMER_CONTROL_ASSERT_SVH
`define TAP_HOLD_DIMMER_CONTROL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define THDC_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define THDC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/thdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap-and-hold dimmer package
// Shared codes, constants and types of the dimmer controller.
// ----------------------------------------------------------------------------
package thdc_pkg;

  typedef enum logic [1:0] {
    OP_POLL      = 2'd0,
    OP_SET_POWER = 2'd1,
    OP_SET_LEVEL = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    REG_USER_RANGE = 2'd0,
    REG_LEVEL_MIN  = 2'd1,
    REG_LEVEL_MAX  = 2'd2,
    REG_WATT_MIN   = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRM_GO,
    S_FRM_WAIT,
    S_PWR_GO,
    S_PWR_WAIT,
    S_LOAD
  } seq_state_e;

  // Status of the switch state machine after the last update.
  typedef struct packed {
    logic       changed;
    logic       power;
    logic [7:0] level;
    logic       send;
  } sw_status_t;

  localparam logic [7:0]  HOLD_COUNT  = 8'd4;
  localparam logic [7:0]  COUNT_MAX   = 8'd255;
  localparam logic [31:0] RELEASE_MS  = 32'd500;
  localparam logic [7:0]  PCT_FULL    = 8'd100;

  localparam logic [7:0]  FRAME_HEAD0 = 8'hFF;
  localparam logic [7:0]  FRAME_HEAD1 = 8'h55;
  localparam logic [7:0]  FRAME_TAIL0 = 8'h05;
  localparam logic [7:0]  FRAME_TAIL1 = 8'hDC;
  localparam logic [7:0]  FRAME_TAIL2 = 8'h0A;

  localparam logic [7:0]  RST_USER_RANGE = 8'd100;
  localparam logic [7:0]  RST_LEVEL_MIN  = 8'd0;
  localparam logic [7:0]  RST_LEVEL_MAX  = 8'd255;
  localparam logic [6:0]  RST_WATT_MIN   = 7'd60;
  localparam logic [7:0]  RST_LEVEL      = 8'd1;

  // Divider: 16-bit magnitude dividend, one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

// File: rtl/thdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap-and-hold dimmer divider
// Signed restoring divider, truncating toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module thdc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] num_i,
  input  logic signed [8:0]  den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [16:0] quot_o
);

  logic                                busy_q, done_q, neg_q;
  logic [thdc_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [7:0]                          den_q, rem_q;
  logic [15:0]                         quo_q;
  logic signed [16:0]                  num_abs;
  logic signed [8:0]                   den_abs;
  logic [8:0]                          rem_sh, rem_sub;
  logic                                fits;

  assign num_abs = num_i[16] ? -num_i : num_i;
  assign den_abs = den_i[8] ? -den_i : den_i;

  assign rem_sh  = {rem_q, quo_q[15]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= thdc_pkg::DIV_CNT_W'(thdc_pkg::DIV_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[16] ^ den_i[8];
      den_q <= den_abs[7:0];
      rem_q <= '0;
      quo_q <= num_abs[15:0];
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[7:0] : rem_sh[7:0];
      quo_q <= {quo_q[14:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// File: rtl/thdc_switch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap-and-hold dimmer switch state
// Press counting, hold ramp, release toggle, level/power writes, second tick.
// ----------------------------------------------------------------------------
module thdc_switch (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   upd_i,
  input  logic [1:0]             operation_i,
  input  logic                   switch_pressed_i,
  input  logic [31:0]            now_ms_i,
  input  logic [5:0]             second_now_i,
  input  logic                   power_value_i,
  input  logic [7:0]             level_value_i,
  input  logic [7:0]             user_range_i,
  output thdc_pkg::sw_status_t   status_o
);

  logic [7:0]      cnt_q, cnt_d;
  logic [31:0]     last_ms_q, last_ms_d;
  thdc_pkg::dir_e  dir_q, dir_d;
  logic            pwr_q, pwr_d;
  logic [7:0]      lvl_q, lvl_d;
  logic [5:0]      sec_q, sec_d;
  logic            chg_q, chg_d;
  logic            send_q, send_d;
  logic [31:0]     elapsed;

  assign elapsed = now_ms_i - last_ms_q;

  always_comb begin
    cnt_d     = cnt_q;
    last_ms_d = last_ms_q;
    dir_d     = dir_q;
    pwr_d     = pwr_q;
    lvl_d     = lvl_q;
    sec_d     = sec_q;
    chg_d     = 1'b0;
    send_d    = 1'b0;
    unique case (thdc_pkg::op_e'(operation_i))
      thdc_pkg::OP_POLL: begin
        if (switch_pressed_i) begin
          if (cnt_q != thdc_pkg::COUNT_MAX) begin
            cnt_d = cnt_q + 1'b1;
          end
          last_ms_d = now_ms_i;
          if (cnt_d > thdc_pkg::HOLD_COUNT) begin
            if (dir_q == thdc_pkg::DIR_NONE) begin
              if (!pwr_q) begin
                pwr_d = 1'b1;
                chg_d = 1'b1;
              end
              dir_d = (lvl_q < user_range_i) ? thdc_pkg::DIR_UP : thdc_pkg::DIR_DOWN;
            end
            // Step toward the end chosen by the first hold
            if (dir_d == thdc_pkg::DIR_UP) begin
              if (lvl_q < user_range_i) begin
                lvl_d = lvl_q + 1'b1;
              end
            end else if (lvl_q > 8'd1) begin
              lvl_d = lvl_q - 1'b1;
            end
          end
        end else if (elapsed > thdc_pkg::RELEASE_MS && cnt_q != '0) begin
          if (cnt_q <= thdc_pkg::HOLD_COUNT) begin
            pwr_d = ~pwr_q;
            chg_d = 1'b1;
          end
          cnt_d = '0;
        end
        if (second_now_i != sec_q) begin
          sec_d  = second_now_i;
          send_d = 1'b1;
        end
      end
      thdc_pkg::OP_SET_POWER: begin
        pwr_d = power_value_i;
      end
      thdc_pkg::OP_SET_LEVEL: begin
        if (level_value_i == '0) begin
          lvl_d = 8'd1;
        end else if (level_value_i > user_range_i) begin
          lvl_d = user_range_i;
        end else begin
          lvl_d = level_value_i;
        end
      end
      thdc_pkg::OP_NOP: begin
        pwr_d = pwr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      last_ms_q <= '0;
      dir_q     <= thdc_pkg::DIR_NONE;
      pwr_q     <= 1'b0;
      lvl_q     <= thdc_pkg::RST_LEVEL;
      sec_q     <= '0;
      chg_q     <= 1'b0;
      send_q    <= 1'b0;
    end else if (upd_i) begin
      cnt_q     <= cnt_d;
      last_ms_q <= last_ms_d;
      dir_q     <= dir_d;
      pwr_q     <= pwr_d;
      lvl_q     <= lvl_d;
      sec_q     <= sec_d;
      chg_q     <= chg_d;
      send_q    <= send_d;
    end
  end

  assign status_o.changed = chg_q;
  assign status_o.power   = pwr_q;
  assign status_o.level   = lvl_q;
  assign status_o.send    = send_q;

endmodule

// File: rtl/tap_hold_dimmer_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap-and-hold dimmer controller
// Wall-switch tap/hold decoding, level ramp, frame and power-percent mapping.
// ----------------------------------------------------------------------------
// Each input word is one operation: a switch poll, a power write or a level
// write. The switch state updates at the accept edge. Then one shared signed
// 16-step serial divider, fed by a single 9x9 multiplier, evaluates the two
// range maps in turn. The first map is the frame level L = map(level, 1,
// user_range, level_min, level_max). The second is the power percent
// map(level, 0, user_range, watt_min, 100). The result word leaves through an
// output register. Each divider pass has a start step, a quotient-bit step for
// each bit of the 16-bit magnitude, and a capture of the result; a load step
// then moves the word into the output register. in_ready_o stays low from the
// accept edge and rises again at the edge that loads the word, so a new word
// is accepted only after the previous one has been loaded. A result word that
// is still waiting in the output register holds the load step, and so holds
// ready low, until the word is taken.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12 and
// must be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "tap_hold_dimmer_control_assert.svh"

module tap_hold_dimmer_control (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic        switch_pressed_i,
  input  logic [31:0] now_ms_i,
  input  logic [5:0]  second_now_i,
  input  logic        power_value_i,
  input  logic [7:0]  level_value_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        changed_o,
  output logic        power_on_o,
  output logic [7:0]  level_now_o,
  output logic        send_frame_o,
  output logic [47:0] frame_o,
  output logic [6:0]  power_percent_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] ur_q, lmin_q, lmax_q;
  logic [6:0] wm_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ur_q   <= thdc_pkg::RST_USER_RANGE;
      lmin_q <= thdc_pkg::RST_LEVEL_MIN;
      lmax_q <= thdc_pkg::RST_LEVEL_MAX;
      wm_q   <= thdc_pkg::RST_WATT_MIN;
    end else if (cfg_wr) begin
      unique case (thdc_pkg::reg_idx_e'(paddr[3:2]))
        thdc_pkg::REG_USER_RANGE: ur_q   <= pwdata[7:0];
        thdc_pkg::REG_LEVEL_MIN:  lmin_q <= pwdata[7:0];
        thdc_pkg::REG_LEVEL_MAX:  lmax_q <= pwdata[7:0];
        thdc_pkg::REG_WATT_MIN:   wm_q   <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (thdc_pkg::reg_idx_e'(paddr[3:2]))
      thdc_pkg::REG_USER_RANGE: prdata = {24'd0, ur_q};
      thdc_pkg::REG_LEVEL_MIN:  prdata = {24'd0, lmin_q};
      thdc_pkg::REG_LEVEL_MAX:  prdata = {24'd0, lmax_q};
      thdc_pkg::REG_WATT_MIN:   prdata = {25'd0, wm_q};
    endcase
  end

  // --------------------------------------------------------------------------
  // Switch state: advance on every accepted word
  // --------------------------------------------------------------------------
  thdc_pkg::seq_state_e state_q, state_d;
  thdc_pkg::sw_status_t sw;
  logic                 in_acc;

  assign in_ready_o = (state_q == thdc_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  thdc_switch u_switch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .upd_i            (in_acc),
    .operation_i      (operation_i),
    .switch_pressed_i (switch_pressed_i),
    .now_ms_i         (now_ms_i),
    .second_now_i     (second_now_i),
    .power_value_i    (power_value_i),
    .level_value_i    (level_value_i),
    .user_range_i     (ur_q),
    .status_o         (sw)
  );

  // --------------------------------------------------------------------------
  // Shared multiply-divide: (x - a) * (d - c) / (b - a)
  // --------------------------------------------------------------------------
  logic signed [8:0]  mul_x, mul_d, div_den;
  logic signed [17:0] prod;
  logic               div_start, div_busy, div_done;
  logic signed [16:0] quot;
  logic               frm_go;
  logic               frm_empty, pwr_empty;

  assign frm_go = (state_q == thdc_pkg::S_FRM_GO);

  // Frame map runs level 1..user_range; percent map runs level 0..user_range.
  assign mul_x   = frm_go ? ($signed({1'b0, sw.level}) - 9'sd1)
                          : $signed({1'b0, sw.level});
  assign mul_d   = frm_go ? ($signed({1'b0, lmax_q}) - $signed({1'b0, lmin_q}))
                          : ($signed({1'b0, thdc_pkg::PCT_FULL}) - $signed({2'b00, wm_q}));
  assign div_den = frm_go ? ($signed({1'b0, ur_q}) - 9'sd1) : $signed({1'b0, ur_q});
  assign prod    = mul_x * mul_d;

  assign frm_empty = (ur_q == 8'd1);
  assign pwr_empty = (ur_q == 8'd0);

  thdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod[16:0]),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic       out_valid_q;
  logic       frm_cap, pct_cap, out_load;
  logic [7:0] frm_lvl_q;
  logic [6:0] pct_q;
  logic [7:0] frm_lvl_d;
  logic [6:0] pct_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thdc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    frm_cap   = 1'b0;
    pct_cap   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      thdc_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = thdc_pkg::S_FRM_GO;
        end
      end
      thdc_pkg::S_FRM_GO: begin
        div_start = 1'b1;
        state_d   = thdc_pkg::S_FRM_WAIT;
      end
      thdc_pkg::S_FRM_WAIT: begin
        if (div_done) begin
          frm_cap = 1'b1;
          state_d = thdc_pkg::S_PWR_GO;
        end
      end
      thdc_pkg::S_PWR_GO: begin
        div_start = 1'b1;
        state_d   = thdc_pkg::S_PWR_WAIT;
      end
      thdc_pkg::S_PWR_WAIT: begin
        if (div_done) begin
          pct_cap = 1'b1;
          state_d = thdc_pkg::S_LOAD;
        end
      end
      thdc_pkg::S_LOAD: begin
        // Hold until the previous result word is taken
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = thdc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = thdc_pkg::S_IDLE;
      end
    endcase
  end

  // Add the low output bound back; an empty input range gives the bound alone, and power off gives frame level 0.
  always_comb begin
    frm_lvl_d = frm_empty ? lmin_q : (quot[7:0] + lmin_q);
    if (!sw.power) begin
      frm_lvl_d = '0;
    end
    pct_d = pwr_empty ? wm_q : (quot[6:0] + wm_q);
  end

  always_ff @(posedge clk_i) begin
    if (frm_cap) begin
      frm_lvl_q <= frm_lvl_d;
    end
    if (pct_cap) begin
      pct_q <= pct_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      changed_o       <= sw.changed;
      power_on_o      <= sw.power;
      level_now_o     <= sw.level;
      send_frame_o    <= sw.send;
      power_percent_o <= pct_q;
      frame_o         <= sw.send ? {thdc_pkg::FRAME_HEAD0, thdc_pkg::FRAME_HEAD1, frm_lvl_q,
                                    thdc_pkg::FRAME_TAIL0, thdc_pkg::FRAME_TAIL1,
                                    thdc_pkg::FRAME_TAIL2}
                                 : 48'd0;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `THDC_ASSERT_SAME(a_ready_div_idle, clk_i, rst_ni, in_ready_o, !div_busy,
                    "input ready while the divider is busy")
  `THDC_ASSERT_NEXT(a_accept_drops_ready, clk_i, rst_ni, in_acc, !in_ready_o,
                    "ready stayed high after an accepted word")
  `THDC_ASSERT_SAME(a_done_in_wait, clk_i, rst_ni, div_done,
                    state_q == thdc_pkg::S_FRM_WAIT || state_q == thdc_pkg::S_PWR_WAIT,
                    "divider finished outside a wait state")

endmodule

// File: tb/sv/tap_hold_dimmer_control_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap-and-hold dimmer controller testbench
// Drives command words into the dimmer and compares every status word with a
// cycle-free software copy of the controller, kept in this file.
// Covers taps, holds, count saturation, time wrap, frame timing and clamping,
// under several register settings and with random stalls on both channels.
// ----------------------------------------------------------------------------
module tap_hold_dimmer_control_tb;
  import thdc_pkg::*;

  // Hard stop for a hung run, far beyond the slowest legal run.
  localparam int unsigned CYCLE_LIMIT   = 500000;
  // Quiet time after the last status word, to catch any unexpected late word.
  localparam int unsigned DRAIN_CYCLES  = 60;
  // Cap the mismatch log so a badly broken block cannot flood the output.
  localparam int unsigned MAX_REPORTS   = 100;
  // Receiver hold-off used to back the block up.
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  // One command word as the sender presents it.
  typedef struct {
    op_e       op;
    bit        pressed;
    bit [31:0] now_ms;
    bit [5:0]  second;
    bit        power_value;
    bit [7:0]  level_value;
  } dimmer_cmd_t;

  // One status word as the block should return it.
  typedef struct {
    bit        changed;
    bit        power_on;
    bit [7:0]  level;
    bit        send_frame;
    bit [47:0] frame;
    bit [6:0]  power_percent;
  } dimmer_status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic        switch_pressed_i;
  logic [31:0] now_ms_i;
  logic [5:0]  second_now_i;
  logic        power_value_i;
  logic [7:0]  level_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        changed_o;
  logic        power_on_o;
  logic [7:0]  level_now_o;
  logic        send_frame_o;
  logic [47:0] frame_o;
  logic [6:0]  power_percent_o;

  // Status words predicted at accept time, oldest first.
  dimmer_status_t pending_status_q[$];

  int unsigned words_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  // Set to run both channels without gaps.
  bit          no_idle        = 1'b0;
  // Nonzero: the receiver holds ready low this many cycles before its next word.
  int unsigned rx_hold_cycles = 0;

  // Stimulus time base: running millisecond clock and clock second.
  bit [31:0] clock_ms  = 32'd0;
  bit [5:0]  clock_sec = 6'd0;

  // Controller copy: configuration registers.
  bit [7:0] cfg_user_range = RST_USER_RANGE;
  bit [7:0] cfg_level_min  = RST_LEVEL_MIN;
  bit [7:0] cfg_level_max  = RST_LEVEL_MAX;
  bit [6:0] cfg_watt_min   = RST_WATT_MIN;

  // Controller copy: switch and light state.
  bit [7:0]  mdl_count    = 8'd0;
  bit [31:0] mdl_last_ms  = 32'd0;
  dir_e      mdl_dir      = DIR_NONE;
  bit        mdl_power    = 1'b0;
  bit [7:0]  mdl_level    = RST_LEVEL;
  bit [5:0]  mdl_last_sec = 6'd0;

  tap_hold_dimmer_control i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .switch_pressed_i (switch_pressed_i),
    .now_ms_i         (now_ms_i),
    .second_now_i     (second_now_i),
    .power_value_i    (power_value_i),
    .level_value_i    (level_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .changed_o        (changed_o),
    .power_on_o       (power_on_o),
    .level_now_o      (level_now_o),
    .send_frame_o     (send_frame_o),
    .frame_o          (frame_o),
    .power_percent_o  (power_percent_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Linear range map with signed math; the quotient truncates toward zero.
  // An empty input range yields the low output value.
  function automatic int range_map(int x, int a, int b, int c, int d);
    if (b == a) return c;
    return (x - a) * (d - c) / (b - a) + c;
  endfunction

  // Advance the controller copy by one command word and return its status.
  function automatic dimmer_status_t dimmer_next(dimmer_cmd_t cmd);
    dimmer_status_t s;
    int             mapped;
    bit [7:0]       frame_level;
    s.changed    = 1'b0;
    s.send_frame = 1'b0;
    s.frame      = 48'd0;
    case (cmd.op)
      OP_POLL: begin
        if (cmd.pressed) begin
          // Count the low sample, stopping at the top of the counter.
          if (mdl_count != COUNT_MAX) mdl_count++;
          mdl_last_ms = cmd.now_ms;
          if (mdl_count > HOLD_COUNT) begin
            // Pick the ramp direction once; it is never cleared afterwards.
            if (mdl_dir == DIR_NONE) begin
              if (!mdl_power) begin
                mdl_power = 1'b1;
                s.changed = 1'b1;
              end
              if (mdl_level < cfg_user_range) mdl_dir = DIR_UP;
              else mdl_dir = DIR_DOWN;
            end
            if (mdl_dir == DIR_UP) begin
              if (mdl_level < cfg_user_range) mdl_level++;
            end else if (mdl_level > 8'd1) begin
              mdl_level--;
            end
          end
        end else if ((cmd.now_ms - mdl_last_ms) > RELEASE_MS && mdl_count != 8'd0) begin
          // Release: a short press toggles power, a hold just ends.
          if (mdl_count <= HOLD_COUNT) begin
            mdl_power = ~mdl_power;
            s.changed = 1'b1;
          end
          mdl_count = 8'd0;
        end
        // Any change of the second, in range or not, sends a frame.
        if (cmd.second != mdl_last_sec) begin
          mdl_last_sec = cmd.second;
          mapped = range_map(int'(mdl_level), 1, int'(cfg_user_range),
                             int'(cfg_level_min), int'(cfg_level_max));
          frame_level = mdl_power ? mapped[7:0] : 8'd0;
          s.send_frame = 1'b1;
          s.frame = {FRAME_HEAD0, FRAME_HEAD1, frame_level,
                     FRAME_TAIL0, FRAME_TAIL1, FRAME_TAIL2};
        end
      end
      OP_SET_POWER: begin
        mdl_power = cmd.power_value;
      end
      OP_SET_LEVEL: begin
        if (cmd.level_value < 8'd1) mdl_level = 8'd1;
        else if (cmd.level_value > cfg_user_range) mdl_level = cfg_user_range;
        else mdl_level = cmd.level_value;
      end
      default: begin
      end
    endcase
    s.power_on = mdl_power;
    s.level    = mdl_level;
    mapped = range_map(int'(mdl_level), 0, int'(cfg_user_range),
                       int'(cfg_watt_min), int'(PCT_FULL));
    s.power_percent = mapped[6:0];
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, logic [47:0] exp_val,
                                      logic [47:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h",
                 $time, name, exp_val, act_val);
    end
  endfunction

  // Compare every status word taken by the receiver with the oldest prediction.
  always @(posedge clk_i) begin
    dimmer_status_t exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: status word with none expected, expected none actual level %0h",
                   $time, level_now_o);
      end else begin
        exp_s = pending_status_q.pop_front();
        check_field("changed",       48'(exp_s.changed),       48'(changed_o));
        check_field("power_on",      48'(exp_s.power_on),      48'(power_on_o));
        check_field("level_now",     48'(exp_s.level),         48'(level_now_o));
        check_field("send_frame",    48'(exp_s.send_frame),    48'(send_frame_o));
        check_field("frame",         exp_s.frame,              frame_o);
        check_field("power_percent", 48'(exp_s.power_percent), 48'(power_percent_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: draw a gap per word, or serve a requested long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (no_idle) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 10);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog: count cycles and stop a run that never drains.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender side helpers
  // --------------------------------------------------------------------------

  // Offer one command word after a random gap; predict it once accepted.
  // Leave valid high on return so a back-to-back word needs no toggle.
  task automatic send_word(input dimmer_cmd_t cmd);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= cmd.op;
    switch_pressed_i <= cmd.pressed;
    now_ms_i         <= cmd.now_ms;
    second_now_i     <= cmd.second;
    power_value_i    <= cmd.power_value;
    level_value_i    <= cmd.level_value;
    do @(posedge clk_i); while (!in_ready_o);
    pending_status_q.push_back(dimmer_next(cmd));
    words_sent++;
  endtask

  // Switch poll; fill the unused fields with noise.
  task automatic send_poll(input bit pressed, input bit [31:0] at_ms, input bit [5:0] sec);
    dimmer_cmd_t cmd;
    cmd.op          = OP_POLL;
    cmd.pressed     = pressed;
    cmd.now_ms      = at_ms;
    cmd.second      = sec;
    cmd.power_value = 1'($urandom_range(0, 1));
    cmd.level_value = 8'($urandom_range(0, 255));
    send_word(cmd);
  endtask

  // Power write, level write or no-op; poll fields carry noise.
  task automatic send_setting(input op_e op, input bit pval, input bit [7:0] lval);
    dimmer_cmd_t cmd;
    cmd.op          = op;
    cmd.pressed     = 1'($urandom_range(0, 1));
    cmd.now_ms      = $urandom;
    cmd.second      = 6'($urandom_range(0, 63));
    cmd.power_value = pval;
    cmd.level_value = lval;
    send_word(cmd);
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase, then a return to idle.
  task automatic write_register(input reg_idx_e idx, input bit [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_USER_RANGE: cfg_user_range = value;
      REG_LEVEL_MIN:  cfg_level_min  = value;
      REG_LEVEL_MAX:  cfg_level_max  = value;
      default:        cfg_watt_min   = value[6:0];
    endcase
    @(posedge clk_i);
  endtask

  // Load a full register set while the block is idle.
  task automatic apply_settings(input bit [7:0] range_top, input bit [7:0] out_min,
                                input bit [7:0] out_max, input bit [6:0] pct_min);
    wait_drained();
    write_register(REG_USER_RANGE, range_top);
    write_register(REG_LEVEL_MIN,  out_min);
    write_register(REG_LEVEL_MAX,  out_max);
    write_register(REG_WATT_MIN,   {1'b0, pct_min});
  endtask

  // Next clock second: mostly steady, sometimes one tick on, rarely out of range.
  function automatic bit [5:0] draw_second();
    int unsigned r;
    r = $urandom_range(0, 39);
    if (r == 0) return 6'($urandom_range(60, 63));
    if (r < 10) clock_sec = (clock_sec == 6'd59) ? 6'd0 : clock_sec + 6'd1;
    return clock_sec;
  endfunction

  // Release poll some time after the last low sample; sometimes land on the
  // 500 ms boundary, where no release may be seen.
  task automatic send_release(input bit [31:0] press_ms);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) clock_ms = press_ms + RELEASE_MS;
    else if (r == 1) clock_ms = press_ms + RELEASE_MS + 32'd1;
    else clock_ms = press_ms + $urandom_range(501, 1500);
    send_poll(1'b0, clock_ms, draw_second());
  endtask

  // Mostly well-formed taps and holds with random timing, plus register-style
  // commands and some noise polls with arbitrary time and switch level.
  task automatic run_mixed_traffic(input int unsigned n_words);
    int unsigned target;
    int unsigned pick;
    int unsigned presses;
    bit [31:0]   press_ms;
    target = words_sent + n_words;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // Tap or hold: a run of low samples, maybe early high polls, a release.
        presses = (pick < 35) ? $urandom_range(1, 4) : $urandom_range(5, 30);
        repeat (presses) begin
          clock_ms += $urandom_range(1, 100);
          send_poll(1'b1, clock_ms, draw_second());
        end
        press_ms = clock_ms;
        repeat ($urandom_range(0, 2)) begin
          clock_ms += $urandom_range(1, 200);
          send_poll(1'b0, clock_ms, draw_second());
        end
        send_release(press_ms);
      end else if (pick < 72) begin
        if ($urandom_range(0, 1) == 0)
          send_setting(OP_SET_LEVEL, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        else
          send_setting(OP_SET_LEVEL, 1'($urandom_range(0, 1)),
                       8'($urandom_range(1, int'(cfg_user_range))));
      end else if (pick < 82) begin
        send_setting(OP_SET_POWER, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        send_setting(OP_NOP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        // Noise: jump the time base anywhere, arbitrary switch level and second.
        clock_ms = $urandom;
        send_poll(1'($urandom_range(0, 1)), clock_ms, 6'($urandom_range(0, 63)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: clamps, every operation, hold from off, tap at the 500 ms
  // boundary, sticky ramp direction and a release across the time wrap.
  task automatic test_directed();
    int unsigned i;
    // Out-of-range second still differs from the stored one: frame, level 0.
    send_poll(1'b0, 32'd10, 6'd63);
    send_setting(OP_SET_LEVEL, 1'b0, 8'd0);
    send_setting(OP_SET_LEVEL, 1'b1, 8'd255);
    send_setting(OP_SET_POWER, 1'b1, 8'd0);
    // Powered frame carries the mapped level.
    send_poll(1'b0, 32'd20, 6'd5);
    send_setting(OP_NOP, 1'b1, 8'hFF);
    send_setting(OP_SET_POWER, 1'b0, 8'd1);
    // Hold from off: fifth low sample powers on and picks the direction.
    for (i = 0; i < 5; i++) send_poll(1'b1, 32'd1000 + i, 6'd5);
    send_poll(1'b0, 32'd1600, 6'd6);
    // Tap: exactly 500 ms is not yet a release, 501 ms toggles.
    send_poll(1'b1, 32'd2000, 6'd6);
    send_poll(1'b1, 32'd2010, 6'd6);
    send_poll(1'b0, 32'd2510, 6'd6);
    send_poll(1'b0, 32'd2511, 6'd7);
    // Sticky direction: with power off, a new hold neither powers on nor
    // turns the ramp around.
    send_setting(OP_SET_LEVEL, 1'b0, 8'd1);
    for (i = 0; i < 5; i++) send_poll(1'b1, 32'd3000 + i, 6'd7);
    send_poll(1'b0, 32'd3600, 6'd8);
    // Time wrap: elapsed time is taken modulo 2^32.
    send_poll(1'b1, 32'hFFFF_FF00, 6'd8);
    send_poll(1'b0, 32'h0000_00F4, 6'd9);
    send_poll(1'b0, 32'h0000_00F5, 6'd9);
    clock_ms  = 32'h0000_0100;
    clock_sec = 6'd9;
  endtask

  // Press past the top of the counter, release, then tap to see it cleared.
  task automatic test_count_saturation();
    int unsigned i;
    for (i = 0; i < 262; i++) begin
      clock_ms += 32'd1;
      send_poll(1'b1, clock_ms, draw_second());
    end
    clock_ms += 32'd600;
    send_poll(1'b0, clock_ms, draw_second());
    clock_ms += 32'd50;
    send_poll(1'b1, clock_ms, draw_second());
    clock_ms += 32'd700;
    send_poll(1'b0, clock_ms, draw_second());
  endtask

  // Register extremes: reversed and full output ranges, the smallest user
  // range, and a level left above a lowered user range.
  task automatic test_config_extremes();
    apply_settings(8'd2, 8'd255, 8'd0, 7'd100);
    send_setting(OP_SET_POWER, 1'b1, 8'd0);
    send_setting(OP_SET_LEVEL, 1'b0, 8'd2);
    send_poll(1'b0, clock_ms, 6'd20);
    send_setting(OP_SET_LEVEL, 1'b0, 8'd1);
    send_poll(1'b0, clock_ms, 6'd21);
    apply_settings(8'd255, 8'd0, 8'd255, 7'd0);
    send_setting(OP_SET_LEVEL, 1'b0, 8'd200);
    send_poll(1'b0, clock_ms, 6'd22);
    // Lower the range under the level; the level stays until written.
    wait_drained();
    write_register(REG_USER_RANGE, 8'd2);
    send_poll(1'b0, clock_ms, 6'd23);
    send_setting(OP_SET_LEVEL, 1'b0, 8'd9);
    send_poll(1'b0, clock_ms, 6'd24);
    clock_sec = 6'd24;
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering
  // words, so the block fills and holds its input; then drain fully.
  task automatic test_backpressure();
    wait_drained();
    rx_hold_cycles = HOLD_OFF_CYCLES;
    no_idle = 1'b1;
    run_mixed_traffic(24);
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Random traffic under several register settings, one burst phase among them.
  task automatic test_random_settings();
    int unsigned phase;
    apply_settings(RST_USER_RANGE, RST_LEVEL_MIN, RST_LEVEL_MAX, RST_WATT_MIN);
    run_mixed_traffic(100);
    apply_settings(8'd2, 8'd255, 8'd0, 7'd100);
    run_mixed_traffic(80);
    apply_settings(8'd255, 8'd0, 8'd255, 7'd0);
    run_mixed_traffic(100);
    for (phase = 0; phase < 3; phase++) begin
      apply_settings(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 7'($urandom_range(0, 100)));
      // Run the first random phase with no gaps on either side.
      no_idle = (phase == 0);
      run_mixed_traffic((phase == 0) ? 50 : 90);
      no_idle = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= 4'd0;
    pwdata           <= 32'd0;
    in_valid_i       <= 1'b0;
    operation_i      <= OP_NOP;
    switch_pressed_i <= 1'b0;
    now_ms_i         <= 32'd0;
    second_now_i     <= 6'd0;
    power_value_i    <= 1'b0;
    level_value_i    <= 8'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_count_saturation();
    test_config_extremes();
    test_backpressure();
    test_random_settings();

    // Drain, then keep watching the output for anything unexpected.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/thdc_pkg.sv
rtl/thdc_div.sv
rtl/thdc_switch.sv
rtl/tap_hold_dimmer_control.sv
tb/sv/tap_hold_dimmer_control_tb.sv
